// File: rtl/rie_pkg.sv
// ----------------------------------------------------------------------------
// rie_pkg: shared types and codes for the instruction execute block
// Opcodes, store kinds, register codes, operand/result structs.
// ----------------------------------------------------------------------------
`default_nettype none

package rie_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned PC_W     = 12;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned OP_W     = 8;
  localparam int unsigned IMM_W    = 12;
  localparam int unsigned SHAMT_W  = 5;
  localparam int unsigned IO_COUNT = 32;
  localparam int unsigned IO_AW    = $clog2(IO_COUNT);

  typedef logic [DATA_W-1:0]       data_t;
  typedef logic [PC_W-1:0]         pc_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [OP_W-1:0]         op_t;
  typedef logic signed [IMM_W-1:0] imm_t;
  typedef logic [1:0]              skind_t;

  // Opcodes
  localparam op_t OP_ADD  = 8'd0;
  localparam op_t OP_SUB  = 8'd1;
  localparam op_t OP_MAC  = 8'd2;
  localparam op_t OP_AND  = 8'd3;
  localparam op_t OP_OR   = 8'd4;
  localparam op_t OP_XOR  = 8'd5;
  localparam op_t OP_SLL  = 8'd6;
  localparam op_t OP_SRL  = 8'd7;
  localparam op_t OP_SRA  = 8'd8;
  localparam op_t OP_BEQ  = 8'd9;
  localparam op_t OP_BNE  = 8'd10;
  localparam op_t OP_BLT  = 8'd11;
  localparam op_t OP_BGT  = 8'd12;
  localparam op_t OP_BLE  = 8'd13;
  localparam op_t OP_BGE  = 8'd14;
  localparam op_t OP_JAL  = 8'd15;
  localparam op_t OP_LW   = 8'd16;
  localparam op_t OP_SW   = 8'd17;
  localparam op_t OP_JIO  = 8'd18;
  localparam op_t OP_IN   = 8'd19;
  localparam op_t OP_OUT  = 8'd20;
  localparam op_t OP_HALT = 8'd21;

  // Store kinds
  localparam skind_t SK_NONE = 2'd0;
  localparam skind_t SK_DMEM = 2'd1;
  localparam skind_t SK_IO   = 2'd2;

  // Special register indexes
  localparam idx_t REG_ZERO = 4'd0;
  localparam idx_t REG_IMM1 = 4'd1;
  localparam idx_t REG_IMM2 = 4'd2;

  // IO register that holds the indirect jump target
  localparam logic [IO_AW-1:0] JUMP_IO = IO_AW'(7);

  typedef struct packed {
    data_t a;
    data_t b;
    data_t c;
  } opnd_t;

  typedef struct packed {
    data_t value;
    logic  taken;
  } alu_res_t;

  typedef struct packed {
    pc_t    next_pc;
    logic   halted;
    logic   bad_opcode;
    logic   reg_written;
    idx_t   reg_index;
    data_t  reg_value;
    skind_t store_kind;
    pc_t    store_addr;
    data_t  store_data;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/rie_if.sv
// ----------------------------------------------------------------------------
// rie_if: valid/ready channels of the instruction execute block
// Instruction channel in, result channel out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rie_in_if;
  logic              valid;
  logic              ready;
  logic [7:0]        opcode;
  logic [3:0]        dest_reg;
  logic [3:0]        src_a_reg;
  logic [3:0]        src_b_reg;
  logic [3:0]        src_c_reg;
  logic signed [11:0] immediate_one;
  logic signed [11:0] immediate_two;

  modport source (
    output valid, opcode, dest_reg, src_a_reg, src_b_reg, src_c_reg,
           immediate_one, immediate_two,
    input  ready
  );
  modport sink (
    input  valid, opcode, dest_reg, src_a_reg, src_b_reg, src_c_reg,
           immediate_one, immediate_two,
    output ready
  );
endinterface

interface rie_out_if;
  logic               valid;
  logic               ready;
  logic [11:0]        next_pc;
  logic               halted;
  logic               bad_opcode;
  logic               reg_written;
  logic [3:0]         reg_index;
  logic signed [31:0] reg_value;
  logic [1:0]         store_kind;
  logic [11:0]        store_addr;
  logic signed [31:0] store_data;

  modport source (
    output valid, next_pc, halted, bad_opcode, reg_written, reg_index, reg_value,
           store_kind, store_addr, store_data,
    input  ready
  );
  modport sink (
    input  valid, next_pc, halted, bad_opcode, reg_written, reg_index, reg_value,
           store_kind, store_addr, store_data,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/rie_alu.sv
// ----------------------------------------------------------------------------
// rie_alu: arithmetic, logic, shift and branch compare unit
// Three-operand ALU and signed branch condition, purely combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module rie_alu (
  input  rie_pkg::op_t     op_i,
  input  rie_pkg::opnd_t   opnd_i,
  output rie_pkg::alu_res_t res_o
);
  import rie_pkg::*;

  data_t              a, b, c;
  logic [SHAMT_W-1:0] shamt;
  logic               lt, gt;

  assign a     = opnd_i.a;
  assign b     = opnd_i.b;
  assign c     = opnd_i.c;
  assign shamt = b[SHAMT_W-1:0];
  assign lt    = $signed(a) < $signed(b);
  assign gt    = $signed(b) < $signed(a);

  always_comb begin
    unique case (op_i)
      OP_ADD:  res_o.value = a + b + c;
      OP_SUB:  res_o.value = a - b - c;
      OP_MAC:  res_o.value = a * b + c;
      OP_AND:  res_o.value = a & b & c;
      OP_OR:   res_o.value = a | b | c;
      OP_XOR:  res_o.value = a ^ b ^ c;
      OP_SLL:  res_o.value = a << shamt;
      OP_SRL:  res_o.value = a >> shamt;
      OP_SRA:  res_o.value = data_t'($signed(a) >>> shamt);
      default: res_o.value = '0;
    endcase

    unique case (op_i)
      OP_BEQ:  res_o.taken = (a == b);
      OP_BNE:  res_o.taken = (a != b);
      OP_BLT:  res_o.taken = lt;
      OP_BGT:  res_o.taken = gt;
      OP_BLE:  res_o.taken = !gt;
      OP_BGE:  res_o.taken = !lt;
      default: res_o.taken = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/rie_dmem.sv
// ----------------------------------------------------------------------------
// rie_dmem: single-port data memory
// One access per cycle, registered read data, old data on a same-cycle write.
// ----------------------------------------------------------------------------
`default_nettype none

module rie_dmem #(
  parameter int unsigned AW = 12
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [AW-1:0]  addr_i,
  input  rie_pkg::data_t wdata_i,
  output rie_pkg::data_t rdata_o
);
  import rie_pkg::*;

  localparam int unsigned DEPTH = 1 << AW;

  data_t mem_q [DEPTH];
  data_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/risc_instruction_execute_top.sv
// ----------------------------------------------------------------------------
// risc_instruction_execute_top: execute stage of a 16-register processor
// Runs one decoded instruction per word and reports pc, writeback and stores.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one decoded instruction per word; out_o returns one result
//   word per instruction, in order (next pc, halt/illegal flags, register
//   writeback, store to data memory or IO registers).
//   Throughput: one instruction per cycle while ready is high. A result goes
//   through stage one, stage two and the output buffer. Stage one reads the
//   register file (registered read, done at acceptance) and executes; stage
//   two adds the data-memory read word for loads. Dependent instructions
//   forward from stage two and the last write: back-to-back words never wait.
//   Reset: registers, pc, IO registers and halt flag clear at once; the data
//   memory is then swept to zero, one word per cycle, all 2**DMEM_AW words
//   (4096 by default), with ready held low until the sweep ends.
//   Stall: results queue in a 4-word output buffer; ready drops when the
//   buffer and the two stages together hold 4 words, so nothing is lost.
//   After a halt or an illegal opcode every instruction returns the frozen pc
//   with halted set and has no other effect.
// ----------------------------------------------------------------------------
`default_nettype none

module risc_instruction_execute_top #(
  parameter int unsigned REG_COUNT = 16,
  parameter int unsigned DMEM_AW   = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rie_in_if.sink     in_i,
  rie_out_if.source  out_o
);
  import rie_pkg::*;

  localparam int unsigned RF_AW      = $clog2(REG_COUNT);
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned CREDIT_W   = CNT_W + 1;
  localparam logic [IDX_W:0] REG_LIMIT = (IDX_W + 1)'(REG_COUNT);

  function automatic data_t sext_imm(input imm_t v);
    return {{(DATA_W - IMM_W){v[IMM_W-1]}}, v};
  endfunction

  // Resolve one operand: fixed registers, then the newest in-flight write.
  function automatic data_t pick_opnd(
    input idx_t  idx,
    input data_t rf_data,
    input logic  rf_vld,
    input imm_t  imm1,
    input imm_t  imm2,
    input logic  fwd_v,
    input idx_t  fwd_idx,
    input data_t fwd_val,
    input logic  wb_v,
    input idx_t  wb_idx,
    input data_t wb_val
  );
    data_t r;
    if (idx == REG_ZERO) begin
      r = '0;
    end else if (idx == REG_IMM1) begin
      r = sext_imm(imm1);
    end else if (idx == REG_IMM2) begin
      r = sext_imm(imm2);
    end else if ({1'b0, idx} >= REG_LIMIT) begin
      r = '0;
    end else if (fwd_v && fwd_idx == idx) begin
      r = fwd_val;
    end else if (wb_v && wb_idx == idx) begin
      r = wb_val;
    end else begin
      r = rf_vld ? rf_data : '0;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Signals
  // --------------------------------------------------------------------------
  logic in_fire;

  // stage one
  logic  s1_v_q;
  op_t   s1_op_q;
  idx_t  s1_rd_q, s1_rs_q, s1_rt_q, s1_rm_q;
  imm_t  s1_imm1_q, s1_imm2_q;

  // register file: two copies, two read ports each
  data_t              rf_a [REG_COUNT];
  data_t              rf_b [REG_COUNT];
  logic [REG_COUNT-1:0] rv_q;
  data_t              rs_data_q, rt_data_q, rm_data_q, rd_data_q;
  logic               rs_vld_q, rt_vld_q, rm_vld_q, rd_vld_q;
  logic               rf_we;
  logic [RF_AW-1:0]   rf_waddr;
  data_t              rf_wdata;

  // last register write, for the read that overlapped it
  logic  wb_v_q;
  idx_t  wb_idx_q;
  data_t wb_val_q;

  // architectural state
  pc_t   pc_q;
  logic  halt_q;
  data_t io_q [IO_COUNT];

  // stage one datapath
  data_t            opnd_a, opnd_b, opnd_c, opnd_d;
  opnd_t            alu_opnd;
  alu_res_t         alu_res;
  data_t            sum_ab;
  logic [DMEM_AW-1:0] dmem_addr;
  logic [IO_AW-1:0] io_addr;
  pc_t              pc_inc;
  res_t             s1_res;
  logic             halt_set;
  logic             wr_req, wr_ok, is_load, dmem_st, io_st;
  data_t            wval;

  // stage two
  logic  s2_v_q;
  res_t  s2_res_q;
  logic  s2_load_q;
  data_t s2_val_q;
  data_t s2_final;
  res_t  s2_out;
  logic  s2_wr;

  // data memory and clear sweep
  logic               clr_q;
  logic [DMEM_AW-1:0] clr_cnt_q;
  logic               dmem_we;
  logic [DMEM_AW-1:0] dmem_port_addr;
  data_t              dmem_wdata;
  data_t              dmem_rdata;

  // output buffer
  res_t                fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                push, pop;
  logic [CREDIT_W-1:0] credit;
  res_t                head;

  // --------------------------------------------------------------------------
  // Input handshake
  // --------------------------------------------------------------------------
  assign credit   = CREDIT_W'(cnt_q) + CREDIT_W'(s1_v_q) + CREDIT_W'(s2_v_q);
  assign in_i.ready = !clr_q && (credit < CREDIT_W'(FIFO_DEPTH));
  assign in_fire  = in_i.valid && in_i.ready;

  // --------------------------------------------------------------------------
  // Register file (read at acceptance, written from stage two)
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_a[rf_waddr] <= rf_wdata;
      rf_b[rf_waddr] <= rf_wdata;
    end
    rs_data_q <= rf_a[in_i.src_a_reg[RF_AW-1:0]];
    rt_data_q <= rf_a[in_i.src_b_reg[RF_AW-1:0]];
    rm_data_q <= rf_b[in_i.src_c_reg[RF_AW-1:0]];
    rd_data_q <= rf_b[in_i.dest_reg[RF_AW-1:0]];
  end

  // --------------------------------------------------------------------------
  // Stage one: operands, execute, commit pc/halt/stores
  // --------------------------------------------------------------------------
  assign opnd_a = pick_opnd(s1_rs_q, rs_data_q, rs_vld_q, s1_imm1_q, s1_imm2_q,
                            s2_wr, s2_res_q.reg_index, s2_final,
                            wb_v_q, wb_idx_q, wb_val_q);
  assign opnd_b = pick_opnd(s1_rt_q, rt_data_q, rt_vld_q, s1_imm1_q, s1_imm2_q,
                            s2_wr, s2_res_q.reg_index, s2_final,
                            wb_v_q, wb_idx_q, wb_val_q);
  assign opnd_c = pick_opnd(s1_rm_q, rm_data_q, rm_vld_q, s1_imm1_q, s1_imm2_q,
                            s2_wr, s2_res_q.reg_index, s2_final,
                            wb_v_q, wb_idx_q, wb_val_q);
  assign opnd_d = pick_opnd(s1_rd_q, rd_data_q, rd_vld_q, s1_imm1_q, s1_imm2_q,
                            s2_wr, s2_res_q.reg_index, s2_final,
                            wb_v_q, wb_idx_q, wb_val_q);

  assign alu_opnd = '{a: opnd_a, b: opnd_b, c: opnd_c};

  rie_alu u_alu (
    .op_i   (s1_op_q),
    .opnd_i (alu_opnd),
    .res_o  (alu_res)
  );

  assign sum_ab    = opnd_a + opnd_b;
  assign dmem_addr = sum_ab[DMEM_AW-1:0];
  assign io_addr   = sum_ab[IO_AW-1:0];
  assign pc_inc    = pc_q + PC_W'(1);

  always_comb begin
    s1_res         = '0;
    s1_res.next_pc = pc_q;
    halt_set       = 1'b0;
    wr_req         = 1'b0;
    is_load        = 1'b0;
    dmem_st        = 1'b0;
    io_st          = 1'b0;
    wval           = '0;
    if (halt_q) begin
      s1_res.halted = 1'b1;
    end else begin
      s1_res.next_pc = pc_inc;
      unique case (s1_op_q) inside
        [OP_ADD:OP_SRA]: begin
          wr_req = 1'b1;
          wval   = alu_res.value;
        end
        [OP_BEQ:OP_BGE]: begin
          if (alu_res.taken) begin
            s1_res.next_pc = opnd_c[PC_W-1:0];
          end
        end
        OP_JAL: begin
          wr_req         = 1'b1;
          wval           = DATA_W'(pc_inc);
          s1_res.next_pc = opnd_c[PC_W-1:0];
        end
        OP_LW: begin
          wr_req  = 1'b1;
          is_load = 1'b1;
          wval    = opnd_c;
        end
        OP_SW: begin
          dmem_st           = 1'b1;
          s1_res.store_kind = SK_DMEM;
          s1_res.store_addr = PC_W'(dmem_addr);
          s1_res.store_data = opnd_d + opnd_c;
        end
        OP_JIO: begin
          s1_res.next_pc = io_q[JUMP_IO][PC_W-1:0];
        end
        OP_IN: begin
          wr_req = 1'b1;
          wval   = io_q[io_addr];
        end
        OP_OUT: begin
          io_st             = 1'b1;
          s1_res.store_kind = SK_IO;
          s1_res.store_addr = PC_W'(io_addr);
          s1_res.store_data = opnd_c;
        end
        default: begin
          // halt and illegal opcodes freeze the pc
          halt_set          = 1'b1;
          s1_res.bad_opcode = (s1_op_q > OP_HALT);
          s1_res.next_pc    = pc_q;
        end
      endcase
      s1_res.halted = halt_set;
    end
    wr_ok              = wr_req && (s1_rd_q != REG_ZERO) && ({1'b0, s1_rd_q} < REG_LIMIT);
    s1_res.reg_written = wr_ok;
    s1_res.reg_index   = wr_ok ? s1_rd_q : '0;
  end

  // --------------------------------------------------------------------------
  // Data memory port: clear sweep after reset, then stores and loads
  // --------------------------------------------------------------------------
  assign dmem_we        = clr_q || (s1_v_q && dmem_st);
  assign dmem_port_addr = clr_q ? clr_cnt_q : dmem_addr;
  assign dmem_wdata     = clr_q ? '0 : s1_res.store_data;

  rie_dmem #(
    .AW (DMEM_AW)
  ) u_dmem (
    .clk_i   (clk_i),
    .we_i    (dmem_we),
    .addr_i  (dmem_port_addr),
    .wdata_i (dmem_wdata),
    .rdata_o (dmem_rdata)
  );

  // --------------------------------------------------------------------------
  // Stage two: finish loads, write back, hand to output buffer
  // --------------------------------------------------------------------------
  assign s2_final = s2_load_q ? dmem_rdata + s2_val_q : s2_val_q;

  always_comb begin
    s2_out           = s2_res_q;
    s2_out.reg_value = s2_final;
  end

  assign s2_wr    = s2_v_q && s2_res_q.reg_written;
  assign rf_we    = s2_wr;
  assign rf_waddr = s2_res_q.reg_index[RF_AW-1:0];
  assign rf_wdata = s2_final;

  // --------------------------------------------------------------------------
  // Output buffer
  // --------------------------------------------------------------------------
  assign push = s2_v_q;
  assign pop  = out_o.valid && out_o.ready;
  assign head = fifo_q[rd_ptr_q];

  assign out_o.valid       = (cnt_q != '0);
  assign out_o.next_pc     = head.next_pc;
  assign out_o.halted      = head.halted;
  assign out_o.bad_opcode  = head.bad_opcode;
  assign out_o.reg_written = head.reg_written;
  assign out_o.reg_index   = head.reg_index;
  assign out_o.reg_value   = head.reg_value;
  assign out_o.store_kind  = head.store_kind;
  assign out_o.store_addr  = head.store_addr;
  assign out_o.store_data  = head.store_data;

  // --------------------------------------------------------------------------
  // Control and state registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      wb_v_q    <= 1'b0;
      pc_q      <= '0;
      halt_q    <= 1'b0;
      rv_q      <= '0;
      io_q      <= '{default: '0};
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      cnt_q     <= '0;
    end else begin
      s1_v_q <= in_fire;
      s2_v_q <= s1_v_q;
      wb_v_q <= s2_wr;
      if (s1_v_q && !halt_q) begin
        pc_q   <= s1_res.next_pc;
        halt_q <= halt_set;
      end
      if (s2_wr) begin
        rv_q[rf_waddr] <= 1'b1;
      end
      if (s1_v_q && io_st) begin
        io_q[io_addr] <= opnd_c;
      end
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + DMEM_AW'(1);
        if (clr_cnt_q == '1) begin
          clr_q <= 1'b0;
        end
      end
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (!push && pop) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q   <= in_i.opcode;
      s1_rd_q   <= in_i.dest_reg;
      s1_rs_q   <= in_i.src_a_reg;
      s1_rt_q   <= in_i.src_b_reg;
      s1_rm_q   <= in_i.src_c_reg;
      s1_imm1_q <= in_i.immediate_one;
      s1_imm2_q <= in_i.immediate_two;
    end
    rs_vld_q  <= rv_q[in_i.src_a_reg[RF_AW-1:0]];
    rt_vld_q  <= rv_q[in_i.src_b_reg[RF_AW-1:0]];
    rm_vld_q  <= rv_q[in_i.src_c_reg[RF_AW-1:0]];
    rd_vld_q  <= rv_q[in_i.dest_reg[RF_AW-1:0]];
    s2_res_q  <= s1_res;
    s2_load_q <= is_load && wr_ok;
    s2_val_q  <= wr_ok ? wval : '0;
    wb_idx_q  <= s2_res_q.reg_index;
    wb_val_q  <= s2_final;
    if (push) begin
      fifo_q[wr_ptr_q] <= s2_out;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit <= CREDIT_W'(FIFO_DEPTH))
    else $error("output buffer and pipeline hold more words than buffer depth");

  a_halt_freezes_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q && $stable(pc_q))
    else $error("pc or halt flag moved after halt");

  a_halt_no_effect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && halt_q) |=> (!s2_res_q.reg_written && s2_res_q.store_kind == SK_NONE))
    else $error("instruction after halt produced a write");

  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> (!s1_v_q && !s2_v_q && !in_i.ready))
    else $error("pipeline active during data memory clear sweep");

endmodule

`default_nettype wire

// File: tb/rie_exec_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rie_exec_checker: result predictor and scoreboard for the execute stage
// Keeps its own register file, pc, data memory, IO registers and halt flag.
// Predicts one result word per accepted instruction word and compares every
// accepted result word, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module rie_exec_checker (
  input  logic clk_i,
  input  logic rst_ni,
  rie_in_if    in_mon,
  rie_out_if   out_mon,
  output int   errors_o,
  output int   pending_o
);
  import rie_pkg::*;

  localparam int unsigned REGS       = 16;
  localparam int unsigned DMEM_AW    = 12;
  localparam int unsigned DMEM_WORDS = 1 << DMEM_AW;

  data_t gpr     [REGS];
  pc_t   pc_q;
  data_t dmem    [DMEM_WORDS];
  data_t io_regs [IO_COUNT];
  bit    frozen;
  res_t  exec_results_q [$];

  function automatic data_t read_gpr(idx_t idx);
    return (idx == REG_ZERO) ? '0 : gpr[idx];
  endfunction

  function automatic res_t execute_instr(op_t op, idx_t rd, idx_t rs, idx_t rt, idx_t rm,
                                         imm_t imm1, imm_t imm2);
    res_t               r;
    data_t              a, b, c, d, sum, val;
    pc_t                npc;
    logic               wr, jump;
    logic [SHAMT_W-1:0] sh;
    r = '0;
    // once stopped, every word just reports the frozen pc
    if (frozen) begin
      r.next_pc = pc_q;
      r.halted  = 1'b1;
      return r;
    end
    gpr[REG_IMM1] = {{(DATA_W-IMM_W){imm1[IMM_W-1]}}, imm1};
    gpr[REG_IMM2] = {{(DATA_W-IMM_W){imm2[IMM_W-1]}}, imm2};
    d    = read_gpr(rd);
    a    = read_gpr(rs);
    b    = read_gpr(rt);
    c    = read_gpr(rm);
    sum  = a + b;
    sh   = b[SHAMT_W-1:0];
    npc  = pc_q + PC_W'(1);
    wr   = 1'b0;
    jump = 1'b0;
    val  = '0;
    case (op)
      OP_ADD: begin wr = 1'b1; val = a + b + c; end
      OP_SUB: begin wr = 1'b1; val = a - b - c; end
      OP_MAC: begin wr = 1'b1; val = a * b + c; end
      OP_AND: begin wr = 1'b1; val = a & b & c; end
      OP_OR:  begin wr = 1'b1; val = a | b | c; end
      OP_XOR: begin wr = 1'b1; val = a ^ b ^ c; end
      OP_SLL: begin wr = 1'b1; val = a << sh; end
      OP_SRL: begin wr = 1'b1; val = a >> sh; end
      OP_SRA: begin wr = 1'b1; val = data_t'($signed(a) >>> sh); end
      OP_BEQ: jump = (a == b);
      OP_BNE: jump = (a != b);
      OP_BLT: jump = ($signed(a) < $signed(b));
      OP_BGT: jump = ($signed(a) > $signed(b));
      OP_BLE: jump = ($signed(a) <= $signed(b));
      OP_BGE: jump = ($signed(a) >= $signed(b));
      OP_JAL: begin
        wr  = 1'b1;
        val = data_t'(npc);
        npc = c[PC_W-1:0];
      end
      OP_LW: begin
        wr  = 1'b1;
        val = dmem[sum[DMEM_AW-1:0]] + c;
      end
      OP_SW: begin
        r.store_kind = SK_DMEM;
        r.store_addr = pc_t'(sum[DMEM_AW-1:0]);
        r.store_data = d + c;
        dmem[sum[DMEM_AW-1:0]] = d + c;
      end
      OP_JIO: npc = io_regs[JUMP_IO][PC_W-1:0];
      OP_IN: begin
        wr  = 1'b1;
        val = io_regs[sum[IO_AW-1:0]];
      end
      OP_OUT: begin
        r.store_kind = SK_IO;
        r.store_addr = pc_t'(sum[IO_AW-1:0]);
        r.store_data = c;
        io_regs[sum[IO_AW-1:0]] = c;
      end
      // halt and every undefined opcode freeze the pc
      default: begin
        r.bad_opcode = (op > OP_HALT);
        frozen       = 1'b1;
        npc          = pc_q;
      end
    endcase
    if (jump) npc = c[PC_W-1:0];
    // drop writes to register zero
    if (wr && rd != REG_ZERO) begin
      gpr[rd]       = val;
      r.reg_written = 1'b1;
      r.reg_index   = rd;
      r.reg_value   = val;
    end
    pc_q      = npc;
    r.next_pc = npc;
    r.halted  = frozen;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h actual 0x%0h", name, exp_v, act_v);
      errors_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t due;
    if (!rst_ni) begin
      foreach (gpr[i]) gpr[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      foreach (io_regs[i]) io_regs[i] = '0;
      pc_q   = '0;
      frozen = 1'b0;
      exec_results_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        exec_results_q.push_back(execute_instr(in_mon.opcode, in_mon.dest_reg,
                                               in_mon.src_a_reg, in_mon.src_b_reg,
                                               in_mon.src_c_reg, in_mon.immediate_one,
                                               in_mon.immediate_two));
      if (out_mon.valid && out_mon.ready) begin
        if (exec_results_q.size() == 0) begin
          $error("result word with no instruction pending");
          errors_o++;
        end else begin
          due = exec_results_q.pop_front();
          check_field("next_pc",     32'(due.next_pc),     32'(out_mon.next_pc));
          check_field("halted",      32'(due.halted),      32'(out_mon.halted));
          check_field("bad_opcode",  32'(due.bad_opcode),  32'(out_mon.bad_opcode));
          check_field("reg_written", 32'(due.reg_written), 32'(out_mon.reg_written));
          check_field("reg_index",   32'(due.reg_index),   32'(out_mon.reg_index));
          check_field("reg_value",   due.reg_value,        out_mon.reg_value);
          check_field("store_kind",  32'(due.store_kind),  32'(out_mon.store_kind));
          check_field("store_addr",  32'(due.store_addr),  32'(out_mon.store_addr));
          check_field("store_data",  due.store_data,       out_mon.store_data);
        end
      end
      pending_o = exec_results_q.size();
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the instruction execute stage
// Sends a directed set of instructions, then a long random program aimed at
// reused memory and IO addresses, and ends with a halt or an undefined
// opcode followed by words that must be ignored. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import rie_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1930;
  localparam int unsigned STALL_LIMIT  = 20000;

  logic clk_i;
  logic rst_ni;
  int   mismatches;
  int   pending;
  int   idle_cycles = 0;
  bit   calm;

  rie_in_if  in_ch ();
  rie_out_if out_ch ();

  risc_instruction_execute_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  rie_exec_checker i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .errors_o  (mismatches),
    .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // immediates: extremes, small values that land on shared addresses, or anything
  function automatic int pick_imm();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 10) return -2048;
    if (sel < 20) return 2047;
    if (sel < 25) return -1;
    if (sel < 55) return int'($urandom_range(15));
    return int'($urandom_range(4095)) - 2048;
  endfunction

  task automatic issue(input op_t op, input int rd, rs, rt, rm, imm1, imm2);
    while (!calm && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= op;
    in_ch.dest_reg      <= idx_t'(rd);
    in_ch.src_a_reg     <= idx_t'(rs);
    in_ch.src_b_reg     <= idx_t'(rt);
    in_ch.src_c_reg     <= idx_t'(rm);
    in_ch.immediate_one <= imm_t'(imm1);
    in_ch.immediate_two <= imm_t'(imm2);
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      out_ch.ready <= calm || ($urandom_range(99) >= 9);
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL risc_instruction_execute_top");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n;
    int unsigned sel;
    op_t         op;
    int          rd, rs, rt, rm;
    rst_ni = 1'b0;
    calm   = 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.opcode        <= OP_ADD;
    in_ch.dest_reg      <= '0;
    in_ch.src_a_reg     <= '0;
    in_ch.src_b_reg     <= '0;
    in_ch.src_c_reg     <= '0;
    in_ch.immediate_one <= '0;
    in_ch.immediate_two <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: operand extremes, every operation but halt, wraps and branches
    issue(OP_ADD, 3, 1, 2, 0, 2047, 2047);
    issue(OP_SUB, 4, 1, 2, 3, -2048, 2047);
    issue(OP_MAC, 5, 1, 2, 3, -2048, -2048);
    issue(OP_SLL, 6, 1, 2, 0, -1, 31);
    issue(OP_SRL, 7, 6, 2, 0, 0, 31);
    issue(OP_SRA, 8, 6, 2, 0, 0, 31);
    issue(OP_SRA, 9, 6, 2, 0, 0, 33);        // only five count bits used
    issue(OP_AND, 10, 8, 1, 5, 240, 0);
    issue(OP_OR, 11, 6, 1, 2, 1365, -1366);
    issue(OP_XOR, 12, 8, 1, 2, -2048, 2047);
    issue(OP_ADD, 0, 1, 2, 0, 5, 6);         // result dropped, pc advances
    issue(OP_BEQ, 0, 1, 2, 1, 100, 100);
    issue(OP_BNE, 0, 1, 2, 1, 100, 100);
    issue(OP_BLT, 0, 1, 2, 1, -5, 3);
    issue(OP_BGT, 0, 1, 2, 2, -5, 3);
    issue(OP_BLE, 0, 1, 2, 1, 7, 7);
    issue(OP_BGE, 0, 6, 8, 1, 300, 0);
    issue(OP_JAL, 13, 0, 0, 2, 0, 2047);
    issue(OP_SW, 11, 1, 2, 5, -1, 5);        // address wraps to 4
    issue(OP_LW, 14, 1, 2, 0, 2, 2);
    issue(OP_OUT, 0, 1, 2, 13, 3, 4);        // jump target into IO register 7
    issue(OP_JIO, 0, 0, 0, 0, 0, 0);
    issue(OP_IN, 15, 1, 2, 0, 20, 19);       // IO address wraps to 7

    for (n = 0; n < RANDOM_WORDS; n++) begin
      calm = (n >= 900 && n < 1200);
      sel  = $urandom_range(99);
      if (sel < 40)      op = op_t'($urandom_range(int'(OP_SRA)));
      else if (sel < 55) op = op_t'($urandom_range(int'(OP_BGE), int'(OP_BEQ)));
      else if (sel < 60) op = OP_JAL;
      else if (sel < 72) op = OP_LW;
      else if (sel < 84) op = OP_SW;
      else if (sel < 87) op = OP_JIO;
      else if (sel < 93) op = OP_IN;
      else               op = OP_OUT;
      rd = $urandom_range(15);
      rs = $urandom_range(15);
      rt = $urandom_range(15);
      rm = $urandom_range(15);
      // aim most memory and IO accesses at the immediates so reads hit earlier writes
      if ((op inside {OP_LW, OP_SW, OP_IN, OP_OUT}) && $urandom_range(9) < 6) begin
        rs = int'(REG_IMM1);
        rt = $urandom_range(1) ? int'(REG_IMM2) : int'(REG_ZERO);
      end
      issue(op, rd, rs, rt, rm, pick_imm(), pick_imm());
    end
    calm = 1'b0;

    // stop the machine, then everything after must be ignored
    if ($urandom_range(1) == 0)
      issue(OP_HALT, $urandom_range(15), 1, 2, 3, pick_imm(), pick_imm());
    else
      issue(op_t'($urandom_range(255, int'(OP_HALT) + 1)), 3, 1, 2, 3, pick_imm(), pick_imm());
    issue(op_t'(8'hFF), 15, 15, 15, 15, -1, -1);
    issue(OP_ADD, 3, 1, 2, 0, 2047, -2048);
    repeat (4)
      issue(op_t'($urandom_range(255)), $urandom_range(15), $urandom_range(15),
            $urandom_range(15), $urandom_range(15), pick_imm(), pick_imm());
    in_ch.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0)
      $display("PASS risc_instruction_execute_top");
    else
      $display("FAIL risc_instruction_execute_top");
    $finish;
  end

endmodule
